// ===== src/hmac_sha1_engine_core_assert.svh =====
// Assertion macros shared by the HMAC-SHA1 engine RTL.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef HMAC_SHA1_ENGINE_CORE_ASSERT_SVH
`define HMAC_SHA1_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define HSHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSHA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hsha_pkg.sv =====
// Types and constants for the HMAC-SHA1 engine.
// No dependencies.
`default_nettype none

package hsha_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       has_byte;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic [63:0] digest_upper;
        logic [63:0] digest_middle;
        logic [31:0] digest_lower;
    } t_out_res;

    typedef logic [15:0][31:0] t_words16;
    typedef logic [4:0][31:0]  t_words5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_CSTART,
        ST_CWAIT,
        ST_BYTE,
        ST_END,
        ST_FPAD,
        ST_FLEN,
        ST_KEYCOPY,
        ST_INNER,
        ST_OCOPY,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_KEY,
        PH_MSG
    } t_phase;

    localparam logic KIND_KEY = 1'b0;

    localparam t_words5 IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] IPAD    = 8'h36;
    localparam logic [7:0] OPAD    = 8'h5C;
    localparam logic [7:0] PAD_ONE = 8'h80;

    localparam logic [6:0] LAST_ROUND = 7'd79;

endpackage

`default_nettype wire

// ===== src/hsha_round.sv =====
// SHA-1 compression unit: one round per cycle, 16-word schedule shift line.
// Depends on hsha_pkg and hmac_sha1_engine_core_assert.svh.
`default_nettype none

module hsha_round (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire hsha_pkg::t_words16 i_block,
    input  wire hsha_pkg::t_words5  i_chain,
    output logic                   o_busy,
    output logic                   o_done,
    output hsha_pkg::t_words5       o_regs
);

    hsha_pkg::t_words16 r_w;
    hsha_pkg::t_words5  r_v;
    logic [6:0]         r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [31:0] mix;
    logic [31:0] wt;
    logic [31:0] f;
    logic [31:0] kc;
    logic [31:0] t;

    always_comb begin
        mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        wt  = (r_cnt < 7'd16) ? r_w[0] : {mix[30:0], mix[31]};
        if (r_cnt < 7'd20) begin
            f  = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            kc = hsha_pkg::K0;
        end else if (r_cnt < 7'd40) begin
            f  = r_v[1] ^ r_v[2] ^ r_v[3];
            kc = hsha_pkg::K1;
        end else if (r_cnt < 7'd60) begin
            f  = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            kc = hsha_pkg::K2;
        end else begin
            f  = r_v[1] ^ r_v[2] ^ r_v[3];
            kc = hsha_pkg::K3;
        end
        t = {r_v[0][26:0], r_v[0][31:27]} + f + r_v[4] + kc + wt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == hsha_pkg::LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= i_block;
            r_v <= i_chain;
        end else if (r_busy) begin
            r_w  <= {wt, r_w[15:1]};
            r_v[4] <= r_v[3];
            r_v[3] <= r_v[2];
            r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
            r_v[1] <= r_v[0];
            r_v[0] <= t;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_regs = r_v;

    `include "hmac_sha1_engine_core_assert.svh"

    `HSHA_ASSERT_NXT(a_done_after_last, r_busy && !i_start && r_cnt == hsha_pkg::LAST_ROUND, r_done && !r_busy, "compression did not finish after the last round")
    `HSHA_ASSERT_IMP(a_cnt_range, r_busy, r_cnt <= hsha_pkg::LAST_ROUND, "round counter out of range")
    `HSHA_ASSERT_NXT(a_start_busy, i_start, r_busy && r_cnt == 7'd0 && !r_done, "start did not begin a compression")

endmodule

`default_nettype wire

// ===== src/hsha_keystore.sv =====
// Key block store: 64 bytes with per-entry valid bits, unwritten reads zero.
// Depends on hmac_sha1_engine_core_assert.svh.
`default_nettype none

module hsha_keystore (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_clear,
    input  wire logic       i_we,
    input  wire logic [5:0] i_waddr,
    input  wire logic [7:0] i_wdata,
    input  wire logic [5:0] i_raddr,
    output logic [7:0]      o_rdata
);

    logic [7:0]  r_mem [64];
    logic [63:0] r_vld;
    logic [7:0]  r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clear) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : 8'h00;
    end

    assign o_rdata = r_rdata;

    `include "hmac_sha1_engine_core_assert.svh"

    `HSHA_ASSERT_NXT(a_clear_empties, i_clear, r_vld == 64'd0, "clear left valid entries")
    `HSHA_ASSERT_NXT(a_write_marks, i_we && !i_clear, r_vld[$past(i_waddr)], "write did not mark entry valid")
    `HSHA_ASSERT_IMP(a_no_clear_write, i_clear, !i_we, "clear and write in one cycle")

endmodule

`default_nettype wire

// ===== src/hmac_sha1_engine_core.sv =====
// HMAC-SHA1 engine, top level.
// Input channel: one request per byte (i_in_data: kind, byte_value, has_byte,
// last) under i_in_valid / o_in_stall. Key requests (kind 0) come first; the
// key is kept for all later messages. A request with has_byte 0 and last 1
// ends an empty key or message.
// Output channel: one 160-bit digest per message under o_out_valid /
// i_out_stall, held in an output register until taken.
// Steps: a plain byte is written into the block buffer. A byte that completes a
// 64-byte block also runs the 80-round compression unit. The first message
// byte adds a key block load and a compression. The last message byte adds
// padding byte writes, three or four compressions and a key block load before
// the digest. A long key adds padding, compression and a key copy at its end.
// One request is handled at a time; o_in_stall is high while busy.
// Reset clears the key to empty and the control state.
// If the previous digest is still stalled, a new digest waits in the
// sequencer until the output register frees.
`default_nettype none

module hmac_sha1_engine_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire hsha_pkg::t_in_req  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output hsha_pkg::t_out_res      o_out_data
);

    hsha_pkg::t_state  r_state, n_state;
    hsha_pkg::t_state  r_cret, n_cret;
    hsha_pkg::t_state  r_fret, n_fret;
    hsha_pkg::t_phase  r_phase, n_phase;
    logic [63:0]       r_count, n_count;
    logic              r_long, n_long;
    hsha_pkg::t_in_req r_req, n_req;
    logic [6:0]        r_idx, n_idx;
    logic [5:0]        r_pos, n_pos;
    logic              r_first, n_first;
    logic [7:0]        r_xv, n_xv;
    hsha_pkg::t_words5 r_chain, n_chain;
    hsha_pkg::t_words5 r_inner, n_inner;
    logic              r_out_valid, n_out_valid;
    hsha_pkg::t_out_res r_out_data, n_out_data;
    hsha_pkg::t_words16 r_buf;

    logic              rnd_start;
    logic              rnd_busy;
    logic              rnd_done;
    hsha_pkg::t_words5 rnd_regs;

    logic              ks_clear;
    logic              ks_we;
    logic [5:0]        ks_waddr;
    logic [7:0]        ks_wdata;
    logic [7:0]        ks_rdata;

    logic              bb_bwe;
    logic [5:0]        bb_bpos;
    logic [7:0]        bb_bval;
    logic              bb_len;
    logic              bb_inner;

    logic [31:0]       cp_word;
    logic [5:0]        pad_pos;

    hsha_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rnd_start),
        .i_block (r_buf),
        .i_chain (r_chain),
        .o_busy  (rnd_busy),
        .o_done  (rnd_done),
        .o_regs  (rnd_regs)
    );

    hsha_keystore u_keystore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (ks_clear),
        .i_we    (ks_we),
        .i_waddr (ks_waddr),
        .i_wdata (ks_wdata),
        .i_raddr (r_idx[5:0]),
        .o_rdata (ks_rdata)
    );

    always_comb begin
        cp_word = r_chain[r_idx[4:2]];
        pad_pos = r_idx[5:0] - 6'd1;
    end

    always_comb begin
        n_state     = r_state;
        n_cret      = r_cret;
        n_fret      = r_fret;
        n_phase     = r_phase;
        n_count     = r_count;
        n_long      = r_long;
        n_req       = r_req;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_first     = r_first;
        n_xv        = r_xv;
        n_chain     = r_chain;
        n_inner     = r_inner;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        rnd_start   = 1'b0;
        ks_clear    = 1'b0;
        ks_we       = 1'b0;
        ks_waddr    = r_count[5:0];
        ks_wdata    = r_req.byte_value;
        bb_bwe      = 1'b0;
        bb_bpos     = r_count[5:0];
        bb_bval     = r_req.byte_value;
        bb_len      = 1'b0;
        bb_inner    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            hsha_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_data;
                    if (i_in_data.has_byte || i_in_data.last) begin
                        if (i_in_data.kind == hsha_pkg::KIND_KEY) begin
                            if (r_phase != hsha_pkg::PH_KEY) begin
                                ks_clear = 1'b1;
                                n_chain  = hsha_pkg::IV;
                                n_count  = '0;
                                n_long   = 1'b0;
                                n_phase  = hsha_pkg::PH_KEY;
                            end
                            n_state = hsha_pkg::ST_BYTE;
                        end else if (r_phase == hsha_pkg::PH_MSG) begin
                            n_state = hsha_pkg::ST_BYTE;
                        end else if (r_phase == hsha_pkg::PH_IDLE) begin
                            n_chain = hsha_pkg::IV;
                            n_phase = hsha_pkg::PH_MSG;
                            n_count = 64'd64;
                            n_xv    = hsha_pkg::IPAD;
                            n_idx   = '0;
                            n_cret  = hsha_pkg::ST_BYTE;
                            n_state = hsha_pkg::ST_PAD;
                        end
                    end
                end
            end
            hsha_pkg::ST_PAD: begin
                n_idx = r_idx + 7'd1;
                if (r_idx != 7'd0) begin
                    bb_bwe  = 1'b1;
                    bb_bpos = pad_pos;
                    bb_bval = ks_rdata ^ r_xv;
                end
                if (r_idx == 7'd64) begin
                    n_state = hsha_pkg::ST_CSTART;
                end
            end
            hsha_pkg::ST_CSTART: begin
                rnd_start = 1'b1;
                n_state   = hsha_pkg::ST_CWAIT;
            end
            hsha_pkg::ST_CWAIT: begin
                if (rnd_done) begin
                    for (int k = 0; k < 5; k++) begin
                        n_chain[k] = r_chain[k] + rnd_regs[k];
                    end
                    n_state = r_cret;
                end
            end
            hsha_pkg::ST_BYTE: begin
                n_state = hsha_pkg::ST_END;
                if (r_req.has_byte) begin
                    if (r_req.kind == hsha_pkg::KIND_KEY) begin
                        if (|r_count[63:6]) begin
                            n_long = 1'b1;
                        end else begin
                            ks_we = 1'b1;
                        end
                    end
                    bb_bwe  = 1'b1;
                    n_count = r_count + 64'd1;
                    if (r_count[5:0] == 6'd63) begin
                        n_cret  = hsha_pkg::ST_END;
                        n_state = hsha_pkg::ST_CSTART;
                    end
                end
            end
            hsha_pkg::ST_END: begin
                n_state = hsha_pkg::ST_IDLE;
                if (r_req.last) begin
                    if (r_req.kind == hsha_pkg::KIND_KEY) begin
                        if (r_long) begin
                            ks_clear = 1'b1;
                            n_idx    = '0;
                            n_fret   = hsha_pkg::ST_KEYCOPY;
                            n_pos    = r_count[5:0];
                            n_first  = 1'b1;
                            n_state  = hsha_pkg::ST_FPAD;
                        end else begin
                            n_phase = hsha_pkg::PH_IDLE;
                        end
                    end else begin
                        n_fret  = hsha_pkg::ST_INNER;
                        n_pos   = r_count[5:0];
                        n_first = 1'b1;
                        n_state = hsha_pkg::ST_FPAD;
                    end
                end
            end
            hsha_pkg::ST_FPAD: begin
                bb_bwe  = 1'b1;
                bb_bpos = r_pos;
                bb_bval = r_first ? hsha_pkg::PAD_ONE : 8'h00;
                n_first = 1'b0;
                n_pos   = r_pos + 6'd1;
                if (r_pos == 6'd55) begin
                    n_state = hsha_pkg::ST_FLEN;
                end else if (r_pos == 6'd63) begin
                    n_cret  = hsha_pkg::ST_FPAD;
                    n_state = hsha_pkg::ST_CSTART;
                end
            end
            hsha_pkg::ST_FLEN: begin
                bb_len  = 1'b1;
                n_cret  = r_fret;
                n_state = hsha_pkg::ST_CSTART;
            end
            hsha_pkg::ST_KEYCOPY: begin
                ks_we    = 1'b1;
                ks_waddr = r_idx[5:0];
                ks_wdata = cp_word[{~r_idx[1:0], 3'b000} +: 8];
                n_idx    = r_idx + 7'd1;
                if (r_idx == 7'd19) begin
                    n_phase = hsha_pkg::PH_IDLE;
                    n_state = hsha_pkg::ST_IDLE;
                end
            end
            hsha_pkg::ST_INNER: begin
                n_inner = r_chain;
                n_chain = hsha_pkg::IV;
                n_xv    = hsha_pkg::OPAD;
                n_idx   = '0;
                n_cret  = hsha_pkg::ST_OCOPY;
                n_state = hsha_pkg::ST_PAD;
            end
            hsha_pkg::ST_OCOPY: begin
                bb_inner = 1'b1;
                n_count  = 64'd84;
                n_pos    = 6'd20;
                n_first  = 1'b1;
                n_fret   = hsha_pkg::ST_OUT;
                n_state  = hsha_pkg::ST_FPAD;
            end
            hsha_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_data.digest_upper  = {r_chain[0], r_chain[1]};
                    n_out_data.digest_middle = {r_chain[2], r_chain[3]};
                    n_out_data.digest_lower  = r_chain[4];
                    n_out_valid = 1'b1;
                    n_phase     = hsha_pkg::PH_IDLE;
                    n_state     = hsha_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hsha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsha_pkg::ST_IDLE;
            r_phase     <= hsha_pkg::PH_IDLE;
            r_count     <= '0;
            r_long      <= 1'b0;
            r_out_valid <= 1'b0;
            r_chain     <= hsha_pkg::IV;
            r_inner     <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_long      <= n_long;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
            r_inner     <= n_inner;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cret     <= n_cret;
        r_fret     <= n_fret;
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_first    <= n_first;
        r_xv       <= n_xv;
        r_out_data <= n_out_data;
        if (bb_bwe) begin
            r_buf[bb_bpos[5:2]][{~bb_bpos[1:0], 3'b000} +: 8] <= bb_bval;
        end
        if (bb_len) begin
            r_buf[14] <= {r_count[60:29]};
            r_buf[15] <= {r_count[28:0], 3'b000};
        end
        if (bb_inner) begin
            for (int k = 0; k < 5; k++) begin
                r_buf[k] <= r_inner[k];
            end
        end
    end

    assign o_in_stall  = (r_state != hsha_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `include "hmac_sha1_engine_core_assert.svh"

    `HSHA_ASSERT_IMP(a_start_when_free, rnd_start, !rnd_busy, "compression started while busy")
    `HSHA_ASSERT_IMP(a_idle_no_round, r_state == hsha_pkg::ST_IDLE, !rnd_busy, "idle with compression running")
    `HSHA_ASSERT_IMP(a_out_from_seq, $rose(r_out_valid), $past(r_state) == hsha_pkg::ST_OUT, "digest appeared outside output step")

endmodule

`default_nettype wire
